// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by sample_table_range_search
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define STS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sts_pkg.sv =====
// ---------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the sample table range search block
// ---------------------------------------------------------------------------
package sts_pkg;

	localparam int ADDR_W      = 12;
	localparam int TABLE_DEPTH = 1 << ADDR_W;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int DATA_W      = 32;
	localparam int RUN_LENGTH  = 3;
	localparam int RUN_W       = $clog2(RUN_LENGTH + 1);

	localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_RANGE_MIN = 2'd1,
		OP_RANGE_MAX = 2'd2,
		OP_WALK      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [2*DATA_W-1:0]   wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} ram_req_t;

endpackage

// ===== design/sts_if.sv =====
// ---------------------------------------------------------------------------
// sts_if
// request and response channels with valid/ready transfer
// ---------------------------------------------------------------------------
interface sts_in_if
	import sts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic [ADDR_W-1:0]        index;
	logic [ADDR_W-1:0]        end_index;
	logic                     channel;
	logic signed [DATA_W-1:0] amplitude_value;
	logic signed [DATA_W-1:0] phase_value;
	logic signed [DATA_W-1:0] threshold;
	logic                     walk_down;

	modport source (
		output valid, operation, index, end_index, channel,
		output amplitude_value, phase_value, threshold, walk_down,
		input  ready
	);
	modport sink (
		input  valid, operation, index, end_index, channel,
		input  amplitude_value, phase_value, threshold, walk_down,
		output ready
	);
endinterface

interface sts_out_if
	import sts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     found;
	logic [ADDR_W-1:0]        found_index;

	modport source (output valid, result_value, found, found_index, input ready);
	modport sink (input valid, result_value, found, found_index, output ready);
endinterface

// ===== design/sample_table_range_search.sv =====
// a write gives no response; a query or walk reads the entries it scans
//   through the table read port, registers its result and then its response,
//   and skips the scan when the table is empty or a query's range is empty
// throughput: one item at a time, set by the single table read port that
//   delivers one entry per cycle; a walk stops early once its run is complete
// reset: arst_n clears the control state and entry_count; the tables are not cleared
// ---------------------------------------------------------------------------
// sample_table_range_search
// signed amplitude/phase tables with range min/max and threshold walk
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_table_range_search
	import sts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	sts_in_if.sink           request,
	sts_out_if.source        response,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0]    entry_count_q;
	ram_req_t            ram_req;
	logic [2*DATA_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	sts_table_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	sts_scan_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count_q),
		.request     (request),
		.response    (response),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

	`STS_ASSERT(a_write_only_on_transfer, clk, arst_n, !ram_req.we || (request.valid && request.ready && request.operation == OP_WRITE), "table write without a write transfer")
	`STS_ASSERT(a_no_read_when_idle, clk, arst_n, !(ram_req.re && request.ready), "table read while accepting requests")
	`STS_ASSERT_NEXT(a_write_no_response, clk, arst_n, request.valid && request.ready && request.operation == OP_WRITE && !response.valid, !response.valid, "write produced a response")
	`STS_ASSERT_NEXT(a_busy_after_query, clk, arst_n, request.valid && request.ready && request.operation != OP_WRITE, !request.ready, "request taken while a query is in progress")

endmodule

// ===== design/sts_table_ram.sv =====
// ---------------------------------------------------------------------------
// sts_table_ram
// amplitude and phase tables side by side, one write and one read port
// ---------------------------------------------------------------------------
module sts_table_ram
	import sts_pkg::*;
(
	input  logic                clk,
	input  ram_req_t            req,
	output logic [2*DATA_W-1:0] rdata
);

	logic [2*DATA_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== design/sts_scan_ctrl.sv =====
// ---------------------------------------------------------------------------
// sts_scan_ctrl
// request decode, address sequencer, min/max and run detector, result register
// ---------------------------------------------------------------------------
module sts_scan_ctrl
	import sts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    entry_count,
	sts_in_if.sink              request,
	sts_out_if.source           response,
	output ram_req_t            ram_req,
	input  logic [2*DATA_W-1:0] ram_rdata
);

	state_t state_q, state_d;

	// captured request
	op_t                      op_q;
	logic                     chan_q;
	logic signed [DATA_W-1:0] thr_q;
	logic                     down_q;

	// address sequencer
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] end_q;
	logic              issuing_q;
	logic              first_q;

	// read beat in flight
	logic              rd_valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              last_s1;
	logic              first_s1;

	// running values
	logic signed [DATA_W-1:0] best_q;
	logic                     first_side_q;
	logic [RUN_W-1:0]         run_q;
	logic [ADDR_W-1:0]        run_start_q;

	// finished result
	logic signed [DATA_W-1:0] res_value_q;
	logic                     res_found_q;
	logic [ADDR_W-1:0]        res_index_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_found_q;
	logic [ADDR_W-1:0]        out_index_q;

	logic accept, is_query, load_out, issue, beat;
	logic [CNT_W-1:0]  n_valid;
	logic [ADDR_W-1:0] last_idx, start_idx, stop_idx;
	logic              table_empty, range_empty;

	logic signed [DATA_W-1:0] v;
	logic signed [DATA_W-1:0] best_n;
	logic                     side, fs_n;
	logic [RUN_W-1:0]         run_n;
	logic [ADDR_W-1:0]        start_n;
	logic                     hit, scan_done;

	// clamp to the valid part of the tables
	always_comb begin
		n_valid     = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
		table_empty = (n_valid == '0);
		last_idx    = ADDR_W'(n_valid - CNT_W'(1));
		start_idx   = (request.index > last_idx) ? last_idx : request.index;
		stop_idx    = (request.end_index > last_idx) ? last_idx : request.end_index;
		range_empty = (start_idx > stop_idx);
		is_query    = (request.operation == OP_RANGE_MIN) ||
			(request.operation == OP_RANGE_MAX);
	end

	// beat processing
	always_comb begin
		v       = chan_q ? ram_rdata[2*DATA_W-1:DATA_W] : ram_rdata[DATA_W-1:0];
		best_n  = best_q;
		if ((op_q == OP_RANGE_MAX) ? (v > best_q) : (v < best_q)) begin
			best_n = v;
		end
		side    = (thr_q > v);
		fs_n    = first_s1 ? side : first_side_q;
		run_n   = '0;
		start_n = run_start_q;
		if (!first_s1 && (side != fs_n)) begin
			run_n = run_q + RUN_W'(1);
			if (run_q == '0) begin
				start_n = addr_s1;
			end
		end
		hit       = (op_q == OP_WALK) && (run_n >= RUN_W'(RUN_LENGTH));
		beat      = (state_q == S_SCAN) && rd_valid_s1;
		scan_done = beat && (last_s1 || hit);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (request.valid && (request.operation != OP_WRITE)) begin
					if (table_empty || (is_query && range_empty)) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || response.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		request.ready = (state_q == S_IDLE);
		accept        = request.valid && request.ready;
		issue         = (state_q == S_SCAN) && issuing_q && !scan_done;
		load_out      = (state_q == S_FINISH) && (!out_valid_q || response.ready);
		ram_req.we    = accept && (request.operation == OP_WRITE) &&
			({1'b0, request.index} < CNT_W'(TABLE_DEPTH));
		ram_req.waddr = request.index;
		ram_req.wdata = {request.phase_value, request.amplitude_value};
		ram_req.re    = issue;
		ram_req.raddr = addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issuing_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (accept) begin
				issuing_q <= 1'b1;
			end else if (issue && (addr_q == end_q)) begin
				issuing_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= request.operation;
			chan_q       <= request.channel;
			thr_q        <= request.threshold;
			down_q       <= request.walk_down && (request.operation == OP_WALK);
			addr_q       <= start_idx;
			first_q      <= 1'b1;
			run_q        <= '0;
			run_start_q  <= '0;
			best_q       <= (request.operation == OP_RANGE_MAX) ? INT_MIN : INT_MAX;
			if (request.operation == OP_WALK) begin
				end_q <= request.walk_down ? '0 : last_idx;
			end else begin
				end_q <= stop_idx;
			end
			// results known without a scan
			res_found_q <= is_query;
			res_index_q <= '0;
			if (table_empty) begin
				res_value_q <= '0;
			end else begin
				res_value_q <= (request.operation == OP_RANGE_MAX) ? INT_MIN : INT_MAX;
			end
		end
		if (issue) begin
			addr_q   <= down_q ? addr_q - ADDR_W'(1) : addr_q + ADDR_W'(1);
			first_q  <= 1'b0;
			addr_s1  <= addr_q;
			last_s1  <= (addr_q == end_q);
			first_s1 <= first_q;
		end
		if (beat) begin
			best_q       <= best_n;
			first_side_q <= fs_n;
			run_q        <= run_n;
			run_start_q  <= start_n;
		end
		if (scan_done) begin
			if (op_q == OP_WALK) begin
				res_value_q <= '0;
				res_found_q <= hit;
				res_index_q <= hit ? start_n : '0;
			end else begin
				res_value_q <= best_n;
				res_found_q <= 1'b1;
				res_index_q <= '0;
			end
		end
		if (load_out) begin
			out_value_q <= res_value_q;
			out_found_q <= res_found_q;
			out_index_q <= res_index_q;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.result_value = out_value_q;
	assign response.found        = out_found_q;
	assign response.found_index  = out_index_q;

endmodule

// ===== dv/tb_sample_table_range_search.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sample_table_range_search
// drives table writes, range min/max queries and threshold walks through the
// request channel, keeps its own copy of both tables and of entry_count,
// works out every response and compares it field by field on transfer
// ---------------------------------------------------------------------------
module tb_sample_table_range_search;
	import sts_pkg::*;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] index;
		logic [ADDR_W-1:0] end_index;
		logic              channel;
		logic [DATA_W-1:0] amp;
		logic [DATA_W-1:0] ph;
		logic [DATA_W-1:0] thr;
		logic              walk_down;
	} query_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              found;
		logic [ADDR_W-1:0] hit_index;
	} answer_t;

	typedef struct packed {
		int      set_count;
		query_t  q;
		logic    typed;
		answer_t want;
	} plan_row_t;

	localparam int KEEP       = -1;
	localparam int PLAN_ROWS  = 25;
	localparam int PHASES     = 12;
	localparam int KNOWN_SPAN = 256;

	// empty table, then eight hand-made entries, then a single-entry table
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{KEEP, '{OP_RANGE_MIN, 12'd0, 12'd4095, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{32'd0, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MAX, 12'd4095, 12'd0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{32'd0, 1'b1, 12'd0}},
		'{KEEP, '{OP_WALK, 12'd4095, 12'd0, 1'b0, 32'd0, 32'd0, INT_MIN, 1'b1},
			1'b1, '{32'd0, 1'b0, 12'd0}},
		'{KEEP, '{OP_WALK, 12'd0, 12'd4095, 1'b1, 32'd0, 32'd0, INT_MAX, 1'b0},
			1'b1, '{32'd0, 1'b0, 12'd0}},
		'{KEEP, '{OP_WRITE, 12'd0, 12'd0, 1'b0, INT_MIN, INT_MAX, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd1, 12'd0, 1'b0, INT_MAX, INT_MIN, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd2, 12'd0, 1'b0, -32'sd5, -32'sd1, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd3, 12'd0, 1'b0, -32'sd5, 32'd0, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd4, 12'd0, 1'b0, -32'sd5, 32'd1, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd5, 12'd0, 1'b0, 32'd20, -32'sd1, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd6, 12'd0, 1'b0, 32'd20, 32'd0, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WRITE, 12'd7, 12'd0, 1'b0, 32'd20, 32'd1, 32'd0, 1'b0},
			1'b0, '0},
		'{8, '{OP_RANGE_MIN, 12'd0, 12'd4095, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MIN, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MAX, 12'd0, 12'd4095, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MAX, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MIN, 12'd5, 12'd2, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MAX, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MAX, 12'd4095, 12'd3, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MIN, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MIN, 12'd4095, 12'd4095, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{32'd20, 1'b1, 12'd0}},
		'{KEEP, '{OP_RANGE_MIN, 12'd1, 12'd6, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MIN, 1'b1, 12'd0}},
		'{KEEP, '{OP_WALK, 12'd2, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WALK, 12'd4095, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1},
			1'b0, '0},
		'{KEEP, '{OP_WALK, 12'd0, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b0, '0},
		'{KEEP, '{OP_WALK, 12'd7, 12'd0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1},
			1'b0, '0},
		'{KEEP, '{OP_WALK, 12'd7, 12'd0, 1'b0, 32'd0, 32'd0, INT_MAX, 1'b0},
			1'b0, '0},
		'{1, '{OP_RANGE_MIN, 12'd4095, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0},
			1'b1, '{INT_MIN, 1'b1, 12'd0}},
		'{KEEP, '{OP_WALK, 12'd3, 12'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1},
			1'b1, '{32'd0, 1'b0, 12'd0}}
	};

	// the last setting is replaced by a random small count
	localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASES] = '{
		13'd1, 13'd3, 13'd16, 13'd8191, 13'd5, 13'd33,
		13'd0, 13'd4095, 13'd64, 13'd2, 13'd4096, 13'd0
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	sts_in_if  req_ch ();
	sts_out_if rsp_ch ();

	sample_table_range_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.response  (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic signed [DATA_W-1:0] amp_copy   [TABLE_DEPTH];
	logic signed [DATA_W-1:0] phase_copy [TABLE_DEPTH];
	logic [CNT_W-1:0]         count_reg;
	answer_t                  pending_answers [$];

	int mismatches;
	int responses_checked;
	int items_sent;
	int walk_hits;
	int settings_used;
	bit steady;
	bit hold_asked;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] stored(input logic ch, input int at);
		return ch ? phase_copy[at] : amp_copy[at];
	endfunction

	function automatic bit compute_answer(input query_t q, output answer_t a);
		int n, lo, hi, j, sel, steps, run, run_start;
		logic signed [DATA_W-1:0] best, v;
		bit first_side, side;
		n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
		a = '0;
		a.found = 1'b1;
		case (q.op)
			OP_WRITE: begin
				amp_copy[q.index]   = q.amp;
				phase_copy[q.index] = q.ph;
				return 1'b0;
			end
			OP_RANGE_MIN, OP_RANGE_MAX: begin
				if (n != 0) begin
					lo = int'(q.index);
					hi = int'(q.end_index);
					if (lo > n - 1) lo = n - 1;
					if (hi > n - 1) hi = n - 1;
					best = (q.op == OP_RANGE_MAX) ? INT_MIN : INT_MAX;
					for (j = lo; j <= hi; j++) begin
						v = stored(q.channel, j);
						if ((q.op == OP_RANGE_MAX) ? (v > best) : (v < best))
							best = v;
					end
					a.value = best;
				end
			end
			default: begin
				a.found = 1'b0;
				if (n != 0) begin
					sel = int'(q.index);
					if (sel > n - 1) sel = n - 1;
					steps = q.walk_down ? sel + 1 : n - sel;
					first_side = $signed(q.thr) > stored(q.channel, sel);
					run = 0;
					run_start = 0;
					for (j = 0; j < steps && run < RUN_LENGTH; j++) begin
						side = $signed(q.thr) > stored(q.channel, sel);
						if (side != first_side) begin
							if (run == 0) run_start = sel;
							run++;
						end else begin
							run = 0;
						end
						sel = q.walk_down ? sel - 1 : sel + 1;
					end
					if (run >= RUN_LENGTH) begin
						a.found     = 1'b1;
						a.hit_index = ADDR_W'(run_start);
					end
				end
			end
		endcase
		return 1'b1;
	endfunction

	// half the levels close to zero so that walks see short runs either side
	function automatic logic [DATA_W-1:0] draw_level();
		case ($urandom_range(0, 7))
			0: return INT_MIN;
			1: return INT_MAX;
			2, 3: return $urandom();
			default: return DATA_W'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	// long tables: only the written entries at both ends of the tables
	function automatic logic [ADDR_W-1:0] draw_spot(input int n);
		if (n > KNOWN_SPAN) begin
			if ($urandom_range(0, 1) == 0)
				return ADDR_W'($urandom_range(0, KNOWN_SPAN - 1));
			return ADDR_W'($urandom_range(TABLE_DEPTH - KNOWN_SPAN, TABLE_DEPTH - 1));
		end
		if ($urandom_range(0, 9) < 4) return ADDR_W'($urandom());
		return ADDR_W'($urandom_range(0, n + 1));
	endfunction

	function automatic query_t draw_query(input int n);
		query_t q;
		int pick, start, limit;
		q.index     = draw_spot(n);
		q.end_index = draw_spot(n);
		q.channel   = 1'($urandom());
		q.amp       = draw_level();
		q.ph        = draw_level();
		q.thr       = draw_level();
		q.walk_down = 1'($urandom());
		pick = $urandom_range(0, 9);
		if (pick < 3) q.op = OP_WRITE;
		else if (pick < 5) q.op = OP_RANGE_MIN;
		else if (pick < 7) q.op = OP_RANGE_MAX;
		else q.op = OP_WALK;
		if (q.op == OP_WRITE && n != 0 && $urandom_range(0, 4) != 0)
			q.index = ADDR_W'($urandom_range(0, n - 1));
		// long tables: keep every scan short and inside the written entries
		if (n > KNOWN_SPAN) begin
			if (q.op == OP_WALK) begin
				start = q.walk_down ? int'($urandom_range(0, 40))
					: n - 1 - int'($urandom_range(0, 40));
				q.index = ADDR_W'(start);
			end else begin
				start = int'(q.index) + int'($urandom_range(0, 40));
				limit = (int'(q.index) < KNOWN_SPAN) ? KNOWN_SPAN - 1 : TABLE_DEPTH - 1;
				q.end_index = ADDR_W'((start > limit) ? limit : start);
			end
		end
		return q;
	endfunction

	task automatic offer(input query_t q, input bit typed, input answer_t want);
		answer_t predicted;
		if (!steady && $urandom_range(0, 99) < 15) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.operation       <= q.op;
		req_ch.index           <= q.index;
		req_ch.end_index       <= q.end_index;
		req_ch.channel         <= q.channel;
		req_ch.amplitude_value <= q.amp;
		req_ch.phase_value     <= q.ph;
		req_ch.threshold       <= q.thr;
		req_ch.walk_down       <= q.walk_down;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		items_sent++;
		if (compute_answer(q, predicted)) begin
			if (q.op == OP_WALK && predicted.found) walk_hits++;
			pending_answers.push_back(typed ? want : predicted);
		end
	endtask

	// only once the block is idle: all responses in and any write finished
	task automatic load_count(input logic [CNT_W-1:0] level);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= level;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = level;
		settings_used++;
	endtask

	initial begin
		answer_t want;
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response with nothing outstanding: value %0d found %0b index %0d",
							$signed(rsp_ch.result_value), rsp_ch.found, rsp_ch.found_index);
				end else begin
					want = pending_answers.pop_front();
					responses_checked++;
					if (rsp_ch.result_value !== want.value || rsp_ch.found !== want.found
							|| rsp_ch.found_index !== want.hit_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display("response %0d: expected %0d/%0b/%0d, got %0d/%0b/%0d",
								responses_checked, $signed(want.value), want.found,
								want.hit_index, $signed(rsp_ch.result_value),
								rsp_ch.found, rsp_ch.found_index);
					end
				end
			end
			if (hold_asked && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	initial begin
		int r, p, k, n;
		plan_row_t row;
		query_t q;
		logic [CNT_W-1:0] level;
		count_reg  = '0;
		steady     = 1'b0;
		hold_asked = 1'b0;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= '0;
		req_ch.valid           <= 1'b0;
		req_ch.operation       <= OP_WRITE;
		req_ch.index           <= '0;
		req_ch.end_index       <= '0;
		req_ch.channel         <= 1'b0;
		req_ch.amplitude_value <= '0;
		req_ch.phase_value     <= '0;
		req_ch.threshold       <= '0;
		req_ch.walk_down       <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_ROWS; r++) begin
			row = PLAN[r];
			if (row.set_count != KEEP) load_count(CNT_W'(row.set_count));
			offer(row.q, row.typed, row.want);
		end

		// both ends of the tables written once so that later scans only see known data
		for (k = 0; k < 2 * KNOWN_SPAN; k++) begin
			q = draw_query(0);
			q.op = OP_WRITE;
			q.index = ADDR_W'((k < KNOWN_SPAN) ? k : TABLE_DEPTH - 2 * KNOWN_SPAN + k);
			offer(q, 1'b0, '0);
		end

		for (p = 0; p < PHASES; p++) begin
			level = (p == PHASES - 1) ? CNT_W'($urandom_range(1, 64)) : PHASE_COUNTS[p];
			load_count(level);
			n = (level > TABLE_DEPTH) ? TABLE_DEPTH : int'(level);
			steady = (p == 1);
			if (p == 4) hold_asked = 1'b1;
			for (k = 0; k < ((n > KNOWN_SPAN) ? 40 : 120); k++)
				offer(draw_query(n), 1'b0, '0);
		end

		req_ch.valid <= 1'b0;
		k = 0;
		while (pending_answers.size() != 0 && k < 20000) begin
			@(posedge clk);
			k++;
		end
		repeat (10) @(posedge clk);
		if (pending_answers.size() != 0) begin
			mismatches += pending_answers.size();
			$display("%0d responses never arrived", pending_answers.size());
		end
		$display("%0d transfers in, %0d responses checked, %0d walk hits", items_sent,
			responses_checked, walk_hits);
		$display("%0d entry_count settings, %0d mismatches", settings_used, mismatches);
		if (mismatches == 0)
			$display("tb_sample_table_range_search passed");
		else
			$display("tb_sample_table_range_search failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("timeout with %0d responses outstanding", pending_answers.size());
		$display("tb_sample_table_range_search failed");
		$finish;
	end

endmodule
